// File: hdl/sstf_pkg.sv
// Shared types and constants for the SSTF disk request scheduler.
`default_nettype none
package sstf_pkg;
   localparam int DEF_QUEUE_DEPTH = 16;
   localparam int DEF_TRACK_BITS  = 16;
   localparam int ID_BITS     = 8;
   localparam int TRK_IO_BITS = 16;
   localparam int DIST_BITS   = 16;
   localparam int LIMIT_BITS  = 5;
   localparam int STATUS_BITS = 2;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 32;
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 5'd16;
   localparam logic [CSR_ADDR_BITS-1:0] REG_QUEUE_LIMIT = 1'b0;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_ACCEPTED = 2'd0,
      ST_SERVED   = 2'd1,
      ST_FULL     = 2'd2,
      ST_EMPTY    = 2'd3
   } status_type;

   localparam logic OP_SUBMIT  = 1'b0;
   localparam logic OP_SERVICE = 1'b1;

   // word passed from front to back through the command queue
   typedef struct packed {
      logic                   op;
      logic [ID_BITS-1:0]     requester_id;
      logic [TRK_IO_BITS-1:0] track;
   } cmd_type;
endpackage
`default_nettype wire

// File: hdl/sstf_disk_request_scheduler.sv
// SSTF disk scheduler: the back end answers a submit word straight from idle; a service word
// goes through a scan that visits one pool entry per cycle for the nearest track (ties to
// the oldest, by a per-entry age rank that the next scan renumbers after a removal), then
// a done state that waits while a held response is stalled. A two-word front queue keeps
// taking words while the back end scans, until it holds two, and a result register holds each response word.
// The pool has valid bits cleared by reset; no clearing pass is needed.
`default_nettype none
module sstf_disk_request_scheduler
   import sstf_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TRACK_BITS  = DEF_TRACK_BITS
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_op,
   input  wire logic [ID_BITS-1:0]       req_requester_id,
   input  wire logic [TRK_IO_BITS-1:0]   req_track,
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic [STATUS_BITS-1:0]        rsp_status,
   output logic [ID_BITS-1:0]            rsp_served_id,
   output logic [TRK_IO_BITS-1:0]        rsp_served_track,
   output logic [DIST_BITS-1:0]          rsp_seek_distance,
   output logic [LIMIT_BITS-1:0]         rsp_occupancy,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready
);
   cmd_type in_cmd, q_cmd;
   logic q_valid, q_take;
   logic [LIMIT_BITS-1:0] limit;

   // tracks are kept at TRACK_BITS inside the back end
   assign in_cmd.op = req_op;
   assign in_cmd.requester_id = req_requester_id;
   assign in_cmd.track = req_track;

   sstf_csr u_csr (
      .clock, .reset, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
      .queue_limit(limit)
   );

   sstf_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .in_cmd,
      .out_valid(q_valid), .out_take(q_take), .out_cmd(q_cmd)
   );

   sstf_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TRACK_BITS(TRACK_BITS)) u_back (
      .clock, .reset, .cmd_valid(q_valid), .cmd_take(q_take), .cmd(q_cmd),
      .queue_limit(limit), .rsp_valid, .rsp_stall, .rsp_status, .rsp_served_id,
      .rsp_served_track, .rsp_seek_distance, .rsp_occupancy
   );
endmodule
`default_nettype wire

// File: hdl/sstf_front.sv
// Front end: a two-entry command queue.
`default_nettype none
module sstf_front
   import sstf_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    in_valid,
   output logic         in_stall,
   input  wire cmd_type in_cmd,
   output logic         out_valid,
   input  wire logic    out_take,
   output cmd_type      out_cmd
);
   cmd_type  q_ff [2];
   cmd_type  q_in [2];
   logic [1:0] cnt_ff, cnt_in;
   logic push, pop;

   assign in_stall  = (cnt_ff == 2'd2);
   assign push      = in_valid && !in_stall;
   assign out_valid = (cnt_ff != 2'd0);
   assign pop       = out_valid && out_take;
   assign out_cmd   = q_ff[0];

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (pop) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_in - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = in_cmd;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end
endmodule
`default_nettype wire

// File: hdl/sstf_back.sv
// Back end: request pool, one-entry-per-cycle nearest-track scan, result register.
`default_nettype none
module sstf_back
   import sstf_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
   parameter int TRACK_BITS  = DEF_TRACK_BITS
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   cmd_valid,
   output logic                        cmd_take,
   input  wire cmd_type                cmd,
   input  wire logic [LIMIT_BITS-1:0]  queue_limit,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output logic [STATUS_BITS-1:0]      rsp_status,
   output logic [ID_BITS-1:0]          rsp_served_id,
   output logic [TRK_IO_BITS-1:0]      rsp_served_track,
   output logic [DIST_BITS-1:0]        rsp_seek_distance,
   output logic [LIMIT_BITS-1:0]       rsp_occupancy
);
   localparam int IDX_BITS  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS  = $clog2(QUEUE_DEPTH + 1);
   localparam int RANK_BITS = IDX_BITS + 1;
   localparam logic [CNT_BITS-1:0] DEPTH_C = CNT_BITS'(QUEUE_DEPTH);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_SCAN = 3'b010,
      S_DONE = 3'b100
   } state_type;

   state_type state_ff, state_in;
   logic [QUEUE_DEPTH-1:0]  valid_ff, valid_in;
   logic [ID_BITS-1:0]      req_mem [QUEUE_DEPTH];
   logic [TRACK_BITS-1:0]   trk_mem [QUEUE_DEPTH];
   logic [TRACK_BITS-1:0]   head_ff, head_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic [IDX_BITS-1:0]     scan_ff, scan_in;
   logic                    found_ff, found_in;
   logic [IDX_BITS-1:0]     best_ff, best_in;
   logic [TRACK_BITS-1:0]   bdist_ff, bdist_in;
   // age rank per entry, 0 = oldest; one spare bit for the pending-removal offset
   logic [RANK_BITS-1:0]    age_mem [QUEUE_DEPTH];
   logic [RANK_BITS-1:0]    bage_ff, bage_in;
   // rank removed by the last service; younger ranks above it drop by one on the next scan
   logic                    pend_ff, pend_in;
   logic [RANK_BITS-1:0]    pend_age_ff, pend_age_in;

   logic                    rv_ff, rv_in;
   logic [STATUS_BITS-1:0]  st_ff, st_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [TRK_IO_BITS-1:0]  tr_ff, tr_in;
   logic [DIST_BITS-1:0]    di_ff, di_in;
   logic [LIMIT_BITS-1:0]   oc_ff, oc_in;

   logic [IDX_BITS-1:0]     free_idx;
   logic [CNT_BITS-1:0]     eff_limit;
   logic [TRACK_BITS-1:0]   cur_trk, d;
   logic [RANK_BITS-1:0]    raw_age, cur_age, new_age;
   logic                    age_fix;
   logic                    wr_en;
   logic                    last;

   always_comb begin
      free_idx = '0;
      for (int k = QUEUE_DEPTH - 1; k >= 0; k--) begin
         if (!valid_ff[k]) free_idx = IDX_BITS'(k);
      end
   end

   assign eff_limit = (32'(queue_limit) > QUEUE_DEPTH) ? DEPTH_C
                                                        : CNT_BITS'(queue_limit);
   assign cur_trk   = trk_mem[scan_ff];
   assign raw_age   = age_mem[scan_ff];
   assign age_fix   = (state_ff == S_SCAN) && valid_ff[scan_ff] && pend_ff &&
                      (raw_age > pend_age_ff);
   assign cur_age   = age_fix ? raw_age - RANK_BITS'(1) : raw_age;
   // a submit while a removal is pending is stored one high; the next scan corrects it
   assign new_age   = RANK_BITS'(count_ff) + RANK_BITS'(pend_ff);
   assign d         = (cur_trk >= head_ff) ? cur_trk - head_ff : head_ff - cur_trk;
   assign last      = (32'(scan_ff) == QUEUE_DEPTH - 1);
   assign cmd_take  = cmd_valid && (state_ff == S_IDLE) && (!rv_ff || !rsp_stall);
   assign wr_en     = cmd_take && cmd.op == OP_SUBMIT && count_ff < eff_limit;

   always_comb begin
      state_in = state_ff; valid_in = valid_ff; head_in = head_ff; count_in = count_ff;
      scan_in = scan_ff; found_in = found_ff; best_in = best_ff; bdist_in = bdist_ff;
      bage_in = bage_ff; pend_in = pend_ff; pend_age_in = pend_age_ff;
      rv_in = rv_ff && rsp_stall;
      st_in = st_ff; id_in = id_ff; tr_in = tr_ff; di_in = di_ff; oc_in = oc_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (cmd_take) begin
               if (cmd.op == OP_SUBMIT) begin
                  id_in = '0; tr_in = '0; di_in = '0;
                  if (wr_en) begin
                     valid_in[free_idx] = 1'b1;
                     count_in = count_ff + CNT_BITS'(1);
                     st_in = ST_ACCEPTED;
                  end else begin
                     st_in = ST_FULL;
                  end
                  oc_in = LIMIT_BITS'(count_in);
                  rv_in = 1'b1;
               end else if (count_ff == '0) begin
                  st_in = ST_EMPTY; id_in = '0; tr_in = '0; di_in = '0;
                  oc_in = '0; rv_in = 1'b1;
               end else begin
                  scan_in = '0; found_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            if (valid_ff[scan_ff] && (!found_ff || d < bdist_ff ||
                (d == bdist_ff && cur_age < bage_ff))) begin
               found_in = 1'b1; best_in = scan_ff; bdist_in = d; bage_in = cur_age;
            end
            if (last) state_in = S_DONE;
            else scan_in = scan_ff + IDX_BITS'(1);
         end
         S_DONE: begin
            if (!rv_ff || !rsp_stall) begin
               valid_in[best_ff] = 1'b0;
               count_in = count_ff - CNT_BITS'(1);
               head_in = trk_mem[best_ff];
               pend_in = 1'b1;
               pend_age_in = bage_ff;
               st_in = ST_SERVED;
               id_in = req_mem[best_ff];
               tr_in = TRK_IO_BITS'(trk_mem[best_ff]);
               di_in = DIST_BITS'(bdist_ff);
               oc_in = LIMIT_BITS'(count_in);
               rv_in = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         req_mem[free_idx] <= cmd.requester_id;
         trk_mem[free_idx] <= TRACK_BITS'(cmd.track);
         age_mem[free_idx] <= new_age;
      end else if (age_fix) begin
         age_mem[scan_ff] <= cur_age;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff <= scan_in; found_ff <= found_in; best_ff <= best_in;
      bdist_ff <= bdist_in; bage_ff <= bage_in; pend_age_ff <= pend_age_in;
      st_ff <= st_in; id_ff <= id_in; tr_ff <= tr_in; di_ff <= di_in; oc_ff <= oc_in;
      if (reset) begin
         state_ff <= S_IDLE; valid_ff <= '0; head_ff <= '0; count_ff <= '0;
         rv_ff <= 1'b0; pend_ff <= 1'b0;
      end else begin
         state_ff <= state_in; valid_ff <= valid_in; head_ff <= head_in;
         count_ff <= count_in; rv_ff <= rv_in; pend_ff <= pend_in;
      end
   end

   assign rsp_valid = rv_ff;
   assign rsp_status = st_ff;
   assign rsp_served_id = id_ff;
   assign rsp_served_track = tr_ff;
   assign rsp_seek_distance = di_ff;
   assign rsp_occupancy = oc_ff;
endmodule
`default_nettype wire

// File: hdl/sstf_csr.sv
// Configuration register file: queue limit.
`default_nettype none
module sstf_csr
   import sstf_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [CSR_ADDR_BITS-1:0] paddr,
   input  wire logic [CSR_DATA_BITS-1:0] pwdata,
   output logic [CSR_DATA_BITS-1:0]      prdata,
   output logic                          pready,
   output logic [LIMIT_BITS-1:0]         queue_limit
);
   logic [LIMIT_BITS-1:0] limit_ff;
   assign pready = 1'b1;
   assign queue_limit = limit_ff;
   assign prdata = (paddr == REG_QUEUE_LIMIT) ? CSR_DATA_BITS'(limit_ff) : '0;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET;
      end else if (psel && penable && pwrite && paddr == REG_QUEUE_LIMIT) begin
         limit_ff <= pwdata[LIMIT_BITS-1:0];
      end
   end
endmodule
`default_nettype wire

// File: hdl/sstf_checker.sv
// Port-level checks for the scheduler.
`default_nettype none
module sstf_checker
   import sstf_pkg::*;
(
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_stall,
   input wire logic [STATUS_BITS-1:0] rsp_status,
   input wire logic [ID_BITS-1:0]     rsp_served_id,
   input wire logic [DIST_BITS-1:0]   rsp_seek_distance,
   input wire logic [LIMIT_BITS-1:0]  rsp_occupancy
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status))
      else $error("response dropped under stall");
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_SERVED |-> rsp_served_id == '0 && rsp_seek_distance == '0)
      else $error("nonzero fields on unserved word");
   a_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ST_EMPTY |-> rsp_occupancy == '0)
      else $error("empty status with occupancy");
   a_occ: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_occupancy <= LIMIT_BITS'(DEF_QUEUE_DEPTH))
      else $error("occupancy above depth");
endmodule

bind sstf_disk_request_scheduler sstf_checker u_chk (
   .clock, .reset, .rsp_valid, .rsp_stall, .rsp_status, .rsp_served_id,
   .rsp_seek_distance, .rsp_occupancy
);
`default_nettype wire
